@@ sv/iqac_pkg.sv @@
// ----------------------------------------------------------------------------
// iqac_pkg
// Shared types, constants and fixed-point helpers for the IQ-to-audio
// channeliser.
// ----------------------------------------------------------------------------
package iqac_pkg;

    localparam int OSC_W      = 18;
    localparam int STAGE_W    = 24;
    localparam int COUNT_W    = 12;
    localparam int AUDIO_W    = 16;
    localparam int CFG_IDX_W  = 3;

    // +1.0 is not representable in Q1.17
    localparam logic signed [OSC_W-1:0] ONE_Q17   = 18'sd131071;
    localparam logic [COUNT_W-1:0]      COUNT_MAX = 12'd4095;

    // Sequencer last step indexes
    localparam logic [3:0] MIX_LAST   = 4'd4;
    localparam logic [3:0] OSC_LAST   = 4'd9;
    localparam logic [3:0] AUDIO_LAST = 4'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TUNING_STEP_RE = 3'd0,
        REG_TUNING_STEP_IM = 3'd1,
        REG_TONE_STEP_RE   = 3'd2,
        REG_TONE_STEP_IM   = 3'd3,
        REG_FILTER_ALPHA   = 3'd4,
        REG_INPUT_RATE     = 3'd5,
        REG_OUTPUT_RATE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_OSC,
        ST_SUM,
        ST_DIV,
        ST_AUDIO,
        ST_OUT
    } state_t;

    // Control handed along the filter chain
    typedef struct packed {
        logic valid;
        logic clear;
    } cell_ctrl_t;

    // Round half up then floor shift
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int unsigned n);
        logic signed [63:0] y;
        y = x + (64'sd1 <<< (n - 1));
        return y >>> n;
    endfunction

    function automatic logic signed [23:0] sat_24(input logic signed [63:0] x);
        if (x > 64'sd8388607) begin
            return 24'sd8388607;
        end else if (x < -64'sd8388608) begin
            return -24'sd8388608;
        end
        return x[23:0];
    endfunction

    function automatic logic signed [17:0] sat_18(input logic signed [63:0] x);
        if (x > 64'sd131071) begin
            return 18'sd131071;
        end else if (x < -64'sd131072) begin
            return -18'sd131072;
        end
        return x[17:0];
    endfunction

    function automatic logic signed [15:0] sat_16(input logic signed [63:0] x);
        if (x > 64'sd32767) begin
            return 16'sd32767;
        end else if (x < -64'sd32768) begin
            return -16'sd32768;
        end
        return x[15:0];
    endfunction

endpackage

@@ sv/iqac_stage_cell.sv @@
// ----------------------------------------------------------------------------
// iqac_stage_cell
// One complex one-pole low-pass stage: st += rnd(alpha * (x - st), 18),
// saturated. Hands its new value and a valid flag to the next cell.
// ----------------------------------------------------------------------------
module iqac_stage_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  iqac_pkg::cell_ctrl_t     ctrl_in,
    input  logic signed [23:0]       in_re,
    input  logic signed [23:0]       in_im,
    input  logic [17:0]              alpha,
    output logic                     out_valid,
    output logic signed [23:0]       out_re,
    output logic signed [23:0]       out_im
);

    logic signed [23:0] st_re_reg, st_im_reg;
    logic signed [23:0] st_re_next, st_im_next;
    logic               valid_reg;
    logic signed [24:0] diff_re, diff_im;
    logic signed [43:0] prod_re, prod_im;

    // Filter update
    always_comb begin
        diff_re    = {in_re[23], in_re} - {st_re_reg[23], st_re_reg};
        diff_im    = {in_im[23], in_im} - {st_im_reg[23], st_im_reg};
        prod_re    = $signed({1'b0, alpha}) * diff_re;
        prod_im    = $signed({1'b0, alpha}) * diff_im;
        st_re_next = iqac_pkg::sat_24(iqac_pkg::rnd_shift(64'(prod_re), 18)
                                      + 64'(st_re_reg));
        st_im_next = iqac_pkg::sat_24(iqac_pkg::rnd_shift(64'(prod_im), 18)
                                      + 64'(st_im_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_re_reg <= '0;
            st_im_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= ctrl_in.valid;
            if (ctrl_in.clear) begin
                st_re_reg <= '0;
                st_im_reg <= '0;
            end else if (ctrl_in.valid) begin
                st_re_reg <= st_re_next;
                st_im_reg <= st_im_next;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = st_re_reg;
    assign out_im    = st_im_reg;

endmodule

@@ sv/iqac_divider.sv @@
// ----------------------------------------------------------------------------
// iqac_divider
// Two-lane restoring divider, one quotient bit per cycle. Divides signed
// 36-bit sums by an unsigned 12-bit count, truncating toward zero.
// ----------------------------------------------------------------------------
module iqac_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [35:0]  dividend_re,
    input  logic signed [35:0]  dividend_im,
    input  logic [11:0]         divisor,
    output logic                done,
    output logic signed [23:0]  quot_re,
    output logic signed [23:0]  quot_im
);

    localparam int ITER = 36;
    localparam int CNT_W = $clog2(ITER);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [35:0]      quo_re_reg, quo_im_reg;
    logic [11:0]      rem_re_reg, rem_im_reg, div_reg;
    logic             neg_re_reg, neg_im_reg;
    logic [35:0]      mag_re, mag_im, qn_re, qn_im;
    logic [12:0]      trial_re, trial_im;
    logic             ge_re, ge_im;

    always_comb begin
        mag_re   = dividend_re[35] ? (~dividend_re + 36'd1) : dividend_re;
        mag_im   = dividend_im[35] ? (~dividend_im + 36'd1) : dividend_im;
        trial_re = {rem_re_reg, quo_re_reg[35]};
        trial_im = {rem_im_reg, quo_im_reg[35]};
        ge_re    = trial_re >= {1'b0, div_reg};
        ge_im    = trial_im >= {1'b0, div_reg};
        qn_re    = neg_re_reg ? (~quo_re_reg + 36'd1) : quo_re_reg;
        qn_im    = neg_im_reg ? (~quo_im_reg + 36'd1) : quo_im_reg;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(ITER - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_re_reg <= mag_re;
            quo_im_reg <= mag_im;
            rem_re_reg <= '0;
            rem_im_reg <= '0;
            neg_re_reg <= dividend_re[35];
            neg_im_reg <= dividend_im[35];
            div_reg    <= divisor;
        end else if (busy_reg) begin
            quo_re_reg <= {quo_re_reg[34:0], ge_re};
            quo_im_reg <= {quo_im_reg[34:0], ge_im};
            rem_re_reg <= ge_re ? 12'(trial_re - {1'b0, div_reg}) : trial_re[11:0];
            rem_im_reg <= ge_im ? 12'(trial_im - {1'b0, div_reg}) : trial_im[11:0];
        end
    end

    assign done    = done_reg;
    assign quot_re = qn_re[23:0];
    assign quot_im = qn_im[23:0];

endmodule

@@ sv/iq_to_audio_channelizer.sv @@
// ----------------------------------------------------------------------------
// iq_to_audio_channelizer
// Tuning mixer, cascade of one-pole complex low-pass cells, summing,
// fractional-rate output timing, mean by division, tone mixing and clamp.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+-------------------------
//  s_      | s_sample_i, s_sample_q, s_restart       | s_valid & s_ready
//  m_      | m_audio                                 | m_valid & m_ready
//  cfg_    | cfg_index, cfg_data                     | cfg_we
//
//  One sample at a time: the next transfer waits for the mixer and tuning
//  oscillator steps on the shared multiplier and the sum step; when an audio
//  output falls due, also for the serial divider, tone mixing, output load and
//  tone oscillator update. The filter cells run beside the tuning oscillator update.
//  Synchronous active-low reset restores registers and signal state.
//  A full output register stalls the sequencer before the tone update.
// ----------------------------------------------------------------------------
module iq_to_audio_channelizer #(
    parameter int STAGES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_i,
    input  logic signed [15:0] s_sample_q,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_audio,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    // Configuration
    logic signed [17:0] tuning_step_re_reg, tuning_step_im_reg;
    logic signed [17:0] tone_step_re_reg, tone_step_im_reg;
    logic [17:0]        filter_alpha_reg;
    logic [23:0]        input_rate_reg;
    logic [17:0]        output_rate_reg;

    // Sequencer
    iqac_pkg::state_t state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic             osc_sel_reg, osc_sel_next;
    logic             accept, restart_clear, div_start, out_load;

    // Datapath
    logic signed [15:0] si_reg, sq_reg;
    logic signed [17:0] tuning_osc_re_reg, tuning_osc_im_reg;
    logic signed [17:0] tone_osc_re_reg, tone_osc_im_reg;
    logic signed [35:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [59:0] prod_reg, acc_reg;
    logic signed [23:0] xr_reg, xi_reg;
    logic               launch_reg;
    logic signed [17:0] nr_reg, ni_reg, ni_fin;
    logic signed [35:0] factor_reg;
    logic signed [63:0] m2, factor_full;
    logic signed [17:0] cur_re, cur_im, stp_re, stp_im;
    logic signed [35:0] sum_re_reg, sum_im_reg;
    logic [11:0]        sum_count_reg;
    logic [24:0]        rate_phase_reg;
    logic               chain_done_reg;
    logic               zero_reg;
    logic signed [23:0] mean_re_reg, mean_im_reg;
    logic signed [15:0] audio_reg, m_audio_reg;
    logic               m_valid_reg;

    // Rate
    logic [23:0] rin, out_rate_ext, rout;
    logic [24:0] phase_sum, phase_wrap;
    logic        fire;

    // Divider and chain
    logic               div_done;
    logic signed [23:0] quot_re, quot_im;
    iqac_pkg::cell_ctrl_t cell_ctrl [STAGES];
    logic               cell_valid [STAGES];
    logic signed [23:0] cell_re [STAGES];
    logic signed [23:0] cell_im [STAGES];

    assign accept        = s_valid && s_ready;
    assign restart_clear = accept && s_restart;
    assign s_ready       = (state_reg == iqac_pkg::ST_IDLE);
    assign out_load      = (state_reg == iqac_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuning_step_re_reg <= iqac_pkg::ONE_Q17;
            tuning_step_im_reg <= '0;
            tone_step_re_reg   <= iqac_pkg::ONE_Q17;
            tone_step_im_reg   <= '0;
            filter_alpha_reg   <= '0;
            input_rate_reg     <= 24'd1000000;
            output_rate_reg    <= 18'd8000;
        end else if (cfg_we) begin
            case (cfg_index)
                iqac_pkg::REG_TUNING_STEP_RE: tuning_step_re_reg <= cfg_data[17:0];
                iqac_pkg::REG_TUNING_STEP_IM: tuning_step_im_reg <= cfg_data[17:0];
                iqac_pkg::REG_TONE_STEP_RE:   tone_step_re_reg   <= cfg_data[17:0];
                iqac_pkg::REG_TONE_STEP_IM:   tone_step_im_reg   <= cfg_data[17:0];
                iqac_pkg::REG_FILTER_ALPHA:   filter_alpha_reg   <= cfg_data[17:0];
                iqac_pkg::REG_INPUT_RATE:     input_rate_reg     <= cfg_data;
                iqac_pkg::REG_OUTPUT_RATE:    output_rate_reg    <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Oscillator operand selection
    always_comb begin
        cur_re = osc_sel_reg ? tone_osc_re_reg : tuning_osc_re_reg;
        cur_im = osc_sel_reg ? tone_osc_im_reg : tuning_osc_im_reg;
        stp_re = osc_sel_reg ? tone_step_re_reg : tuning_step_re_reg;
        stp_im = osc_sel_reg ? tone_step_im_reg : tuning_step_im_reg;
    end

    // Output timing
    always_comb begin
        rin          = (input_rate_reg == 24'd0) ? 24'd1 : input_rate_reg;
        out_rate_ext = {6'd0, output_rate_reg};
        rout         = (out_rate_ext > rin) ? rin : out_rate_ext;
        phase_sum    = rate_phase_reg + {1'b0, rout};
        fire         = phase_sum >= {1'b0, rin};
        phase_wrap   = phase_sum - {1'b0, rin};
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iqac_pkg::ST_IDLE;
            step_reg    <= '0;
            osc_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            osc_sel_reg <= osc_sel_next;
        end
    end

    // Next state and multiplier operands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        osc_sel_next = osc_sel_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        case (state_reg)
            iqac_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = iqac_pkg::ST_MIX;
                    step_next  = '0;
                end
            end
            iqac_pkg::ST_MIX: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(tuning_osc_re_reg); mul_b = 24'(si_reg); end
                    4'd1: begin mul_a = 36'(tuning_osc_im_reg); mul_b = 24'(sq_reg); end
                    4'd2: begin mul_a = 36'(tuning_osc_im_reg); mul_b = 24'(si_reg); end
                    4'd3: begin mul_a = 36'(tuning_osc_re_reg); mul_b = 24'(sq_reg); end
                    default: ;
                endcase
                if (step_reg == iqac_pkg::MIX_LAST) begin
                    state_next   = iqac_pkg::ST_OSC;
                    step_next    = '0;
                    osc_sel_next = 1'b0;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            iqac_pkg::ST_OSC: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(cur_re); mul_b = 24'(stp_re); end
                    4'd1: begin mul_a = 36'(cur_im); mul_b = 24'(stp_im); end
                    4'd2: begin mul_a = 36'(cur_re); mul_b = 24'(stp_im); end
                    4'd3: begin mul_a = 36'(cur_im); mul_b = 24'(stp_re); end
                    4'd4: begin mul_a = 36'(nr_reg); mul_b = 24'(nr_reg); end
                    4'd5: begin mul_a = 36'(ni_reg); mul_b = 24'(ni_reg); end
                    4'd7: begin mul_a = factor_reg;  mul_b = 24'(nr_reg); end
                    4'd8: begin mul_a = factor_reg;  mul_b = 24'(ni_reg); end
                    default: ;
                endcase
                if (step_reg == iqac_pkg::OSC_LAST) begin
                    state_next = osc_sel_reg ? iqac_pkg::ST_IDLE : iqac_pkg::ST_SUM;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            iqac_pkg::ST_SUM: begin
                if (chain_done_reg) begin
                    if (fire) begin
                        state_next = iqac_pkg::ST_DIV;
                        div_start  = 1'b1;
                    end else begin
                        state_next = iqac_pkg::ST_IDLE;
                    end
                end
            end
            iqac_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = iqac_pkg::ST_AUDIO;
                    step_next  = '0;
                end
            end
            iqac_pkg::ST_AUDIO: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(tone_osc_re_reg); mul_b = mean_re_reg; end
                    4'd1: begin mul_a = 36'(tone_osc_im_reg); mul_b = mean_im_reg; end
                    default: ;
                endcase
                if (step_reg == iqac_pkg::AUDIO_LAST) begin
                    state_next = iqac_pkg::ST_OUT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            iqac_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next   = iqac_pkg::ST_OSC;
                    step_next    = '0;
                    osc_sel_next = 1'b1;
                end
            end
            default: state_next = iqac_pkg::ST_IDLE;
        endcase
    end

    // Magnitude correction factor
    always_comb begin
        m2          = 64'(acc_reg) + 64'(prod_reg);
        factor_full = ((64'sd3 <<< 34) - m2) >>> 1;
        ni_fin      = iqac_pkg::sat_18(iqac_pkg::rnd_shift(64'(prod_reg), 34));
    end

    // Shared multiplier and sequenced datapath
    always_ff @(posedge aclk) begin
        prod_reg   <= mul_a * mul_b;
        launch_reg <= (state_reg == iqac_pkg::ST_MIX) && (step_reg == iqac_pkg::MIX_LAST);
        if (accept) begin
            si_reg <= s_sample_i;
            sq_reg <= s_sample_q;
        end
        case (state_reg)
            iqac_pkg::ST_MIX: begin
                case (step_reg)
                    4'd1, 4'd3: acc_reg <= prod_reg;
                    4'd2: xr_reg <= iqac_pkg::sat_24(iqac_pkg::rnd_shift(
                                        64'(acc_reg) - 64'(prod_reg), 10));
                    4'd4: xi_reg <= iqac_pkg::sat_24(iqac_pkg::rnd_shift(
                                        64'(acc_reg) + 64'(prod_reg), 10));
                    default: ;
                endcase
            end
            iqac_pkg::ST_OSC: begin
                case (step_reg)
                    4'd1, 4'd3, 4'd5: acc_reg <= prod_reg;
                    4'd2: nr_reg <= iqac_pkg::sat_18(iqac_pkg::rnd_shift(
                                        64'(acc_reg) - 64'(prod_reg), 17));
                    4'd4: ni_reg <= iqac_pkg::sat_18(iqac_pkg::rnd_shift(
                                        64'(acc_reg) + 64'(prod_reg), 17));
                    4'd6: factor_reg <= factor_full[35:0];
                    4'd8: nr_reg <= iqac_pkg::sat_18(iqac_pkg::rnd_shift(64'(prod_reg), 34));
                    default: ;
                endcase
            end
            iqac_pkg::ST_AUDIO: begin
                case (step_reg)
                    4'd1: acc_reg <= prod_reg;
                    4'd2: audio_reg <= iqac_pkg::sat_16(iqac_pkg::rnd_shift(
                                           64'(acc_reg) - 64'(prod_reg), 24));
                    default: ;
                endcase
            end
            iqac_pkg::ST_DIV: begin
                if (div_done) begin
                    mean_re_reg <= zero_reg ? 24'sd0 : quot_re;
                    mean_im_reg <= zero_reg ? 24'sd0 : quot_im;
                end
            end
            default: ;
        endcase
        if (div_start) begin
            zero_reg <= (sum_count_reg == 12'd0);
        end
    end

    // Oscillator state: advance, restart after collapse to zero, clear
    always_ff @(posedge aclk) begin
        if (!aresetn || restart_clear) begin
            tuning_osc_re_reg <= iqac_pkg::ONE_Q17;
            tuning_osc_im_reg <= '0;
            tone_osc_re_reg   <= iqac_pkg::ONE_Q17;
            tone_osc_im_reg   <= '0;
        end else if ((state_reg == iqac_pkg::ST_OSC) && (step_reg == iqac_pkg::OSC_LAST)) begin
            if (osc_sel_reg) begin
                tone_osc_re_reg <= ((nr_reg == 18'sd0) && (ni_fin == 18'sd0))
                                   ? iqac_pkg::ONE_Q17 : nr_reg;
                tone_osc_im_reg <= ni_fin;
            end else begin
                tuning_osc_re_reg <= ((nr_reg == 18'sd0) && (ni_fin == 18'sd0))
                                     ? iqac_pkg::ONE_Q17 : nr_reg;
                tuning_osc_im_reg <= ni_fin;
            end
        end
    end

    // Filter cell chain
    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_ctrl[g] = '{valid: launch_reg, clear: restart_clear};
                iqac_stage_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl_in   (cell_ctrl[g]),
                    .in_re     (xr_reg),
                    .in_im     (xi_reg),
                    .alpha     (filter_alpha_reg),
                    .out_valid (cell_valid[g]),
                    .out_re    (cell_re[g]),
                    .out_im    (cell_im[g])
                );
            end else begin : g_next
                assign cell_ctrl[g] = '{valid: cell_valid[g-1], clear: restart_clear};
                iqac_stage_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl_in   (cell_ctrl[g]),
                    .in_re     (cell_re[g-1]),
                    .in_im     (cell_im[g-1]),
                    .alpha     (filter_alpha_reg),
                    .out_valid (cell_valid[g]),
                    .out_re    (cell_re[g]),
                    .out_im    (cell_im[g])
                );
            end
        end
    endgenerate

    // Summing, count and output phase
    always_ff @(posedge aclk) begin
        if (!aresetn || restart_clear) begin
            sum_re_reg     <= '0;
            sum_im_reg     <= '0;
            sum_count_reg  <= '0;
            rate_phase_reg <= '0;
            chain_done_reg <= 1'b0;
        end else begin
            if (accept) begin
                chain_done_reg <= 1'b0;
            end else if (cell_valid[STAGES-1]) begin
                chain_done_reg <= 1'b1;
            end
            if (div_start) begin
                sum_re_reg    <= '0;
                sum_im_reg    <= '0;
                sum_count_reg <= '0;
            end else if (cell_valid[STAGES-1] && (sum_count_reg < iqac_pkg::COUNT_MAX)) begin
                sum_re_reg    <= sum_re_reg + 36'(cell_re[STAGES-1]);
                sum_im_reg    <= sum_im_reg + 36'(cell_im[STAGES-1]);
                sum_count_reg <= sum_count_reg + 12'd1;
            end
            if ((state_reg == iqac_pkg::ST_SUM) && chain_done_reg) begin
                if (!fire) begin
                    rate_phase_reg <= phase_sum;
                end else if (phase_wrap >= {1'b0, rin}) begin
                    rate_phase_reg <= {1'b0, rin} - 25'd1;
                end else begin
                    rate_phase_reg <= phase_wrap;
                end
            end
        end
    end

    iqac_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .dividend_re (sum_re_reg),
        .dividend_im (sum_im_reg),
        .divisor     (sum_count_reg),
        .done        (div_done),
        .quot_re     (quot_re),
        .quot_im     (quot_im)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_audio_reg <= audio_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_audio = m_audio_reg;

    // Checks
    a_accept_starts_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == iqac_pkg::ST_MIX))
        else $error("transfer did not start the mixer sequence");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == iqac_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("audio load did not raise output valid");

endmodule

@@ bench/iq_to_audio_channelizer_checker.sv @@
// ----------------------------------------------------------------------------
// iq_to_audio_channelizer_checker
// Watches the sample, audio and register ports of the channeliser, keeps a
// bit-exact prediction of its signal state and compares every audio transfer
// with the oldest predicted sample.
// ----------------------------------------------------------------------------
module iq_to_audio_channelizer_checker #(
    parameter int STAGES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample_i,
    input  logic signed [15:0] s_sample_q,
    input  logic               s_restart,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_audio,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 fail_count,
    output int                 audio_pending,
    output int                 audio_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies
    longint tun_step_re, tun_step_im, tone_step_re, tone_step_im;
    longint alpha, in_rate, out_rate;

    // Signal state
    longint tun_re, tun_im, tone_re, tone_im;
    longint st_re [STAGES];
    longint st_im [STAGES];
    longint acc_re, acc_im, acc_cnt, phase;

    logic signed [iqac_pkg::AUDIO_W-1:0] audio_q [$];

    assign audio_pending = audio_q.size();

    function automatic longint rnd_sh(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint x, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    // Rotate an oscillator by its step, then pull its magnitude back to one
    task automatic rotate(inout longint re, inout longint im, input longint sr,
                          input longint si);
        longint nr, ni, m2, f;
        nr = clip(rnd_sh(re * sr - im * si, 17), iqac_pkg::OSC_W);
        ni = clip(rnd_sh(re * si + im * sr, 17), iqac_pkg::OSC_W);
        m2 = nr * nr + ni * ni;
        f  = (3 * (longint'(1) <<< 34) - m2) / 2;
        nr = clip(rnd_sh(nr * f, 34), iqac_pkg::OSC_W);
        ni = clip(rnd_sh(ni * f, 34), iqac_pkg::OSC_W);
        if (nr == 0 && ni == 0) begin
            nr = iqac_pkg::ONE_Q17;
        end
        re = nr;
        im = ni;
    endtask

    task automatic clear_signal();
        tun_re  = iqac_pkg::ONE_Q17;
        tun_im  = 0;
        tone_re = iqac_pkg::ONE_Q17;
        tone_im = 0;
        for (int s = 0; s < STAGES; s++) begin
            st_re[s] = 0;
            st_im[s] = 0;
        end
        acc_re  = 0;
        acc_im  = 0;
        acc_cnt = 0;
        phase   = 0;
    endtask

    task automatic load_register(logic [2:0] idx, logic [23:0] d);
        case (iqac_pkg::cfg_reg_t'(idx))
            iqac_pkg::REG_TUNING_STEP_RE: begin
                tun_step_re = longint'($signed(d[17:0]));
            end
            iqac_pkg::REG_TUNING_STEP_IM: begin
                tun_step_im = longint'($signed(d[17:0]));
            end
            iqac_pkg::REG_TONE_STEP_RE: begin
                tone_step_re = longint'($signed(d[17:0]));
            end
            iqac_pkg::REG_TONE_STEP_IM: begin
                tone_step_im = longint'($signed(d[17:0]));
            end
            iqac_pkg::REG_FILTER_ALPHA: begin
                alpha = longint'(d[17:0]);
            end
            iqac_pkg::REG_INPUT_RATE: begin
                in_rate = longint'(d);
            end
            iqac_pkg::REG_OUTPUT_RATE: begin
                out_rate = longint'(d[17:0]);
            end
            default: ;
        endcase
    endtask

    // Run one sample through mixer, filter cascade, summing and rate timing, predicting audio on output
    task automatic channelise(logic signed [15:0] si, logic signed [15:0] sq,
                              logic rst);
        longint xi_s, xq_s, xr, xi, rin, rout, p, mr, mi;
        xi_s = longint'(si);
        xq_s = longint'(sq);
        if (rst) begin
            clear_signal();
        end
        xr = clip(rnd_sh(xi_s * tun_re - xq_s * tun_im, 10), iqac_pkg::STAGE_W);
        xi = clip(rnd_sh(xi_s * tun_im + xq_s * tun_re, 10), iqac_pkg::STAGE_W);
        rotate(tun_re, tun_im, tun_step_re, tun_step_im);
        for (int s = 0; s < STAGES; s++) begin
            st_re[s] = clip(st_re[s] + rnd_sh(alpha * (xr - st_re[s]), 18),
                            iqac_pkg::STAGE_W);
            st_im[s] = clip(st_im[s] + rnd_sh(alpha * (xi - st_im[s]), 18),
                            iqac_pkg::STAGE_W);
            xr = st_re[s];
            xi = st_im[s];
        end
        if (acc_cnt < iqac_pkg::COUNT_MAX) begin
            acc_re += xr;
            acc_im += xi;
            acc_cnt++;
        end
        rin  = (in_rate == 0) ? 1 : in_rate;
        rout = (out_rate > rin) ? rin : out_rate;
        p = phase + rout;
        if (p < rin) begin
            phase = p;
        end else begin
            p -= rin;
            if (p >= rin) begin
                p = rin - 1;
            end
            phase = p;
            mr = (acc_cnt == 0) ? 0 : acc_re / acc_cnt;
            mi = (acc_cnt == 0) ? 0 : acc_im / acc_cnt;
            audio_q.insert(audio_q.size(),
                           iqac_pkg::AUDIO_W'(clip(rnd_sh(mr * tone_re - mi * tone_im, 24),
                                                   iqac_pkg::AUDIO_W)));
            rotate(tone_re, tone_im, tone_step_re, tone_step_im);
            acc_re  = 0;
            acc_im  = 0;
            acc_cnt = 0;
        end
    endtask

    task automatic report(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count    = 0;
            audio_checked = 0;
            tun_step_re  = iqac_pkg::ONE_Q17;
            tun_step_im  = 0;
            tone_step_re = iqac_pkg::ONE_Q17;
            tone_step_im = 0;
            alpha        = 0;
            in_rate      = 1000000;
            out_rate     = 8000;
            clear_signal();
            audio_q.delete();
        end else begin
            if (cfg_we) begin
                load_register(cfg_index, cfg_data);
            end
            if (m_valid && m_ready) begin
                audio_checked++;
                if (audio_q.size() == 0) begin
                    report($sformatf("unexpected audio %0d", m_audio));
                end else begin
                    if (m_audio !== audio_q[0]) begin
                        report($sformatf("audio %0d, predicted %0d", m_audio, audio_q[0]));
                    end
                    void'(audio_q.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                channelise(s_sample_i, s_sample_q, s_restart);
            end
        end
    end

endmodule

@@ bench/iq_to_audio_channelizer_tb.sv @@
// ----------------------------------------------------------------------------
// iq_to_audio_channelizer_tb
// Drives samples and register settings into the channeliser with random
// gaps and back-pressure; the checker beside it predicts and compares audio.
// ----------------------------------------------------------------------------
module iq_to_audio_channelizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE      = 120;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample_i;
    logic signed [15:0] s_sample_q;
    logic               s_restart;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_audio;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    int  fail_count, audio_pending, audio_checked;
    int  cycles;
    int  samples_sent;
    int  settings_used;
    bit  hold_req;

    iq_to_audio_channelizer #(.STAGES(4)) DUT (.*);

    iq_to_audio_channelizer_checker #(.STAGES(4)) u_checker (.*);

    // Clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random ready with one long hold-off on request
    initial begin
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                held = 1'b1;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            m_ready <= 1'b0;
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(20, 300)) @(posedge aclk);
            end else if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    // One sample transfer; valid stays high across back-to-back samples
    task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq,
                               logic rst, int gap);
        s_valid    <= 1'b1;
        s_sample_i <= si;
        s_sample_q <= sq;
        s_restart  <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    task automatic random_sample(int gap);
        send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 39) == 0, gap);
    endtask

    // Wait until every predicted audio sample has arrived and the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (audio_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(iqac_pkg::cfg_reg_t idx, logic [23:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup(logic [17:0] tr, logic [17:0] ti, logic [17:0] pr,
                         logic [17:0] pi, logic [17:0] a, logic [23:0] rin,
                         logic [17:0] rout);
        write_reg(iqac_pkg::REG_TUNING_STEP_RE, 24'(tr));
        write_reg(iqac_pkg::REG_TUNING_STEP_IM, 24'(ti));
        write_reg(iqac_pkg::REG_TONE_STEP_RE,   24'(pr));
        write_reg(iqac_pkg::REG_TONE_STEP_IM,   24'(pi));
        write_reg(iqac_pkg::REG_FILTER_ALPHA,   24'(a));
        write_reg(iqac_pkg::REG_INPUT_RATE,     rin);
        write_reg(iqac_pkg::REG_OUTPUT_RATE,    rout);
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic random_setup();
        logic [23:0] rin;
        logic [17:0] rout, a;
        int r;
        r = $urandom_range(0, 9);
        rin  = 24'($urandom_range(1, 40));
        rout = 18'($urandom_range(1, 40));
        if (r == 0) rin = 0;
        if (r == 1) begin
            rin  = 24'hFFFFFF;
            rout = 18'h3FFFF;
        end
        if (r == 2) rout = 0;
        a = 18'($urandom);
        if ($urandom_range(0, 3) == 0) a = $urandom_range(0, 1) ? 18'h3FFFF : 18'h0;
        setup(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom), a, rin, rout);
    endtask

    initial begin
        logic signed [15:0] edge_vals [4];
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_sample_i = '0;
        s_sample_q = '0;
        s_restart  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_req   = 1'b0;
        samples_sent  = 0;
        settings_used = 1;
        edge_vals = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, then extreme steps and full alpha
        for (int k = 0; k < 4; k++) send_sample(edge_vals[k], edge_vals[3 - k], 1'b0, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 1);
        drain();
        setup(18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 18'h3FFFF, 24'd2, 18'd1);
        for (int k = 0; k < 16; k++) begin
            send_sample(edge_vals[k % 4], edge_vals[k / 4], k == 9, k % 3);
        end
        drain();
        // Output rate above input rate, zero input rate
        setup(18'h0, 18'h1FFFF, 18'h1FFFF, 18'h0, 18'h20000, 24'd0, 18'h3FFFF);
        for (int k = 0; k < 4; k++) send_sample(-16'sh8000, 16'sh7FFF, 1'b0, 0);
        drain();

        // Random settings with random samples; the hold-off phase gets a
        // dense output rate so the block fills and stalls its input
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                setup(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                      18'($urandom), 24'd3, 18'd2);
            end else begin
                random_setup();
            end
            for (int n = 0; n < 160; n++) begin
                if (ph == 4 && n == 20) hold_req = 1'b1;
                random_sample((ph == 4 && n >= 20 && n < 80) ? 0 : random_gap());
            end
            drain();
        end

        // Long run without output, then a rate change leaves a stale phase
        setup(18'($urandom), 18'($urandom), 18'h1FFFF, 18'h0, 18'h10000, 24'hFFFFFF, 18'd1);
        for (int n = 0; n < 100; n++) random_sample(0);
        drain();
        write_reg(iqac_pkg::REG_INPUT_RATE, 24'd10);
        write_reg(iqac_pkg::REG_OUTPUT_RATE, 18'd10);
        settings_used++;
        for (int n = 0; n < 20; n++) random_sample(random_gap());
        drain();

        $display("Covered %0d samples and %0d audio results over %0d register settings",
                 samples_sent, audio_checked, settings_used);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/iqac_pkg.sv
sv/iqac_stage_cell.sv
sv/iqac_divider.sv
sv/iq_to_audio_channelizer.sv
bench/iq_to_audio_channelizer_checker.sv
bench/iq_to_audio_channelizer_tb.sv
